// File: rtl/core/mau_pkg.sv
// shared types and constants of the modular arithmetic unit
package mau_pkg;

  localparam int unsigned MUL_W  = 32;
  localparam int unsigned DATA_W = 64;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_DIV   = 4'd3,
    OP_NEG   = 4'd4,
    OP_DBL   = 4'd5,
    OP_SQR   = 4'd6,
    OP_POW   = 4'd7,
    OP_INV   = 4'd8,
    OP_TOM   = 4'd9,
    OP_FROMM = 4'd10,
    OP_ONE   = 4'd11
  } op_e;

  typedef enum logic [2:0] {
    CFG_MODULUS  = 3'd0,
    CFG_WIDTH    = 3'd1,
    CFG_MONT     = 3'd2,
    CFG_ONE      = 3'd3,
    CFG_R2       = 3'd4,
    CFG_NEG_INV  = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    RADIX_8  = 2'd0,
    RADIX_16 = 2'd1,
    RADIX_32 = 2'd2,
    RADIX_64 = 2'd3
  } radix_e;

  typedef enum logic [13:0] {
    S_IDLE     = 14'h0001,
    S_PROD     = 14'h0002,
    S_PDONE    = 14'h0004,
    S_RED      = 14'h0008,
    S_MFIN     = 14'h0010,
    S_FIN      = 14'h0020,
    S_PW_SCAN  = 14'h0040,
    S_PW_SQ    = 14'h0080,
    S_PW_MUL   = 14'h0100,
    S_INV_MOD  = 14'h0200,
    S_INV_LOOP = 14'h0400,
    S_INV_DIV  = 14'h0800,
    S_INV_UPD  = 14'h1000,
    S_INV_ADJ  = 14'h2000
  } state_e;

endpackage

// File: rtl/core/mau_mul.sv
// registered 32x32 partial product multiplier shared by all products
module mau_mul
  import mau_pkg::*;
(
  input  logic                 clk_i,
  input  logic [MUL_W-1:0]     a_i,
  input  logic [MUL_W-1:0]     b_i,
  output logic [2*MUL_W-1:0]   p_o
);

  logic [2*MUL_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// File: rtl/core/modular_arithmetic_unit.sv
// modular arithmetic unit: add/sub/neg/dbl in one pass, products on a shared 32x32 multiplier
// add, sub, neg, dbl, one and unused codes: result formed at accept, registered out in S_FIN
// montgomery multiply: three 4-part products, sum, final subtract
// plain multiply: one 4-part product, then the bit-per-cycle 128-bit reduction
// power: one or two multiplies per exponent bit; inverse/divide: per euclid round a
// 64-bit shift-subtract division plus one plain multiply; one item at a time
// rst_ni clears control state and loads the configuration reset values
module modular_arithmetic_unit
  import mau_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  operation_i,
  input  logic [63:0] operand_a_i,
  input  logic [63:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_o,
  output logic        result_is_zero_o,
  output logic        result_is_one_o,
  output logic        no_inverse_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  localparam logic [63:0] WMASK = {64{1'b1}} >> (64 - OPERAND_WIDTH);
  localparam logic [6:0]  WMAX  = 7'(OPERAND_WIDTH);

  // configuration
  logic [63:0] mod_q, one_q, r2_q, ninv_q;
  logic [6:0]  width_q;
  logic        mont_q;

  // sequencer and datapath
  state_e       state_q, state_d, ret_q, ret_d;
  op_e          op_q, op_d;
  logic [63:0]  a_q, a_d, x_q, x_d, y_q, y_d, z_q, z_d, r_q, r_d, e_q, e_d;
  logic [63:0]  r0_q, r0_d, r1_q, r1_d, t0_q, t0_d, t1_q, t1_d, dq_q, dq_d, rem_q, rem_d;
  logic [127:0] acc_q, acc_d, t_q, t_d;
  logic [128:0] s_q, s_d;
  logic [6:0]   cnt_q, cnt_d;
  logic [5:0]   pos_q, pos_d;
  logic [1:0]   mstep_q, mstep_d;
  logic         mm_mont_q, mm_mont_d, fail_q, fail_d;

  // output register
  logic         out_valid_q, out_valid_d;
  logic [63:0]  res_q, res_d;
  logic         zero_q, zero_d, isone_q, isone_d, noinv_q, noinv_d;

  // call request into the multiply routine
  logic         call_en, call_mont;
  logic [63:0]  call_x, call_y;
  state_e       call_ret;

  logic [63:0]  pp;
  logic [1:0]   pidx;
  logic [127:0] pp_sh;
  logic [6:0]   wc;
  radix_e       radix;
  logic [63:0]  km, one_val, ain, bin, ul, red_r, nt;
  logic         uh;
  logic [64:0]  rem_t;

  function automatic logic [63:0] mod_add(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] p);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[64] || s[63:0] >= p) begin
      s[63:0] = s[63:0] - p;
    end
    return s[63:0] & WMASK;
  endfunction

  function automatic logic [63:0] mod_sub(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] p);
    logic [63:0] d;
    d = a - b;
    if (a < b) begin
      d = d + p;
    end
    return d & WMASK;
  endfunction

  mau_mul u_mul (
    .clk_i (clk_i),
    .a_i   (cnt_q[0] ? x_q[63:32] : x_q[31:0]),
    .b_i   (cnt_q[1] ? y_q[63:32] : y_q[31:0]),
    .p_o   (pp)
  );

  // radix from the clamped declared width
  always_comb begin
    wc = (width_q == 7'd0) ? 7'd1 : width_q;
    if (wc > WMAX) begin
      wc = WMAX;
    end
    if (wc > 7'd32) begin
      radix = RADIX_64;
    end else if (wc > 7'd16) begin
      radix = RADIX_32;
    end else if (wc > 7'd8) begin
      radix = RADIX_16;
    end else begin
      radix = RADIX_8;
    end
  end

  always_comb begin
    case (radix)
      RADIX_8:  begin km = 64'h0000_0000_0000_00FF; ul = s_q[71:8];          uh = 1'b0;      end
      RADIX_16: begin km = 64'h0000_0000_0000_FFFF; ul = s_q[79:16];          uh = 1'b0;      end
      RADIX_32: begin km = 64'h0000_0000_FFFF_FFFF; ul = s_q[95:32];          uh = 1'b0;      end
      default:  begin km = {64{1'b1}};              ul = s_q[127:64];         uh = s_q[128];  end
    endcase
  end

  assign one_val = mont_q ? one_q : 64'd1;
  assign ain     = operand_a_i & WMASK;
  assign bin     = operand_b_i & WMASK;
  assign pidx    = 2'(cnt_q - 7'd1);

  always_comb begin
    case (pidx)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  // one bit of the long reduction
  always_comb begin
    red_r = {r_q[62:0], acc_q[127]};
    if (r_q[63] || red_r >= mod_q) begin
      red_r = red_r - mod_q;
    end
  end

  // one bit of the restoring division
  assign rem_t = {rem_q, dq_q[63]};
  assign nt    = mod_sub(t0_q, z_q, mod_q);

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    op_d        = op_q;
    a_d         = a_q;
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    r_d         = r_q;
    e_d         = e_q;
    r0_d        = r0_q;
    r1_d        = r1_q;
    t0_d        = t0_q;
    t1_d        = t1_q;
    dq_d        = dq_q;
    rem_d       = rem_q;
    acc_d       = acc_q;
    t_d         = t_q;
    s_d         = s_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    mstep_d     = mstep_q;
    mm_mont_d   = mm_mont_q;
    fail_d      = fail_q;
    out_valid_d = out_valid_q && out_stall_i;
    res_d       = res_q;
    zero_d      = zero_q;
    isone_d     = isone_q;
    noinv_d     = noinv_q;
    call_en     = 1'b0;
    call_mont   = 1'b0;
    call_x      = '0;
    call_y      = '0;
    call_ret    = S_FIN;

    unique case (state_q) inside
      S_IDLE: begin
        if (in_valid_i) begin
          op_d   = op_e'(operation_i);
          a_d    = ain;
          fail_d = 1'b0;
          state_d = S_FIN;
          unique case (op_e'(operation_i)) inside
            OP_ADD:   z_d = mod_add(ain, bin, mod_q);
            OP_SUB:   z_d = mod_sub(ain, bin, mod_q);
            OP_NEG:   z_d = (ain == 64'd0) ? 64'd0 : ((mod_q - ain) & WMASK);
            OP_DBL:   z_d = mod_add(ain, ain, mod_q);
            OP_ONE:   z_d = one_val;
            OP_MUL: begin
              call_en = 1'b1; call_x = ain; call_y = bin; call_mont = mont_q;
            end
            OP_SQR: begin
              call_en = 1'b1; call_x = ain; call_y = ain; call_mont = mont_q;
            end
            OP_TOM: begin
              call_en = 1'b1; call_x = ain; call_y = r2_q; call_mont = 1'b1;
            end
            OP_FROMM: begin
              call_en = 1'b1; call_x = ain; call_y = 64'd1; call_mont = 1'b1;
            end
            OP_POW: begin
              z_d     = one_val;
              e_d     = bin;
              pos_d   = '0;
              state_d = S_PW_SCAN;
            end
            OP_INV, OP_DIV: begin
              if (mod_q < 64'd2) begin
                z_d     = '0;
                fail_d  = 1'b1;
                state_d = S_INV_ADJ;
              end else begin
                call_en  = 1'b1;
                call_x   = (op_e'(operation_i) == OP_INV) ? ain : bin;
                call_y   = 64'd1;
                call_ret = S_INV_MOD;
              end
            end
            default:  z_d = '0;
          endcase
        end
      end
      S_PROD: begin
        if (cnt_q != 7'd0) begin
          acc_d = acc_q + pp_sh;
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd4) begin
          state_d = S_PDONE;
        end
      end
      S_PDONE: begin
        if (!mm_mont_q) begin
          if (mod_q == 64'd0) begin
            z_d     = acc_q[63:0];
            state_d = ret_q;
          end else begin
            r_d     = '0;
            cnt_d   = '0;
            state_d = S_RED;
          end
        end else if (mstep_q == 2'd0) begin
          // m = t * n mod R
          t_d     = acc_q;
          x_d     = acc_q[63:0];
          y_d     = ninv_q & km;
          mstep_d = 2'd1;
          acc_d   = '0;
          cnt_d   = '0;
          state_d = S_PROD;
        end else if (mstep_q == 2'd1) begin
          x_d     = acc_q[63:0] & km;
          y_d     = mod_q & km;
          mstep_d = 2'd2;
          acc_d   = '0;
          cnt_d   = '0;
          state_d = S_PROD;
        end else begin
          s_d     = {1'b0, t_q} + {1'b0, acc_q};
          state_d = S_MFIN;
        end
      end
      S_RED: begin
        r_d   = red_r;
        acc_d = {acc_q[126:0], 1'b0};
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd127) begin
          z_d     = red_r;
          state_d = ret_q;
        end
      end
      S_MFIN: begin
        if (uh || ul >= (mod_q & km)) begin
          z_d = (ul - (mod_q & km)) & km & WMASK;
        end else begin
          z_d = ul & km & WMASK;
        end
        state_d = ret_q;
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          res_d       = z_q & WMASK;
          zero_d      = ((z_q & WMASK) == 64'd0);
          isone_d     = ((z_q & WMASK) == (one_val & WMASK));
          noinv_d     = fail_q;
          state_d     = S_IDLE;
        end
      end
      S_PW_SCAN: begin
        if (e_q == 64'd0) begin
          state_d = S_FIN;
        end else if (e_q[63]) begin
          call_en = 1'b1; call_x = z_q; call_y = z_q; call_mont = mont_q;
          call_ret = S_PW_SQ;
        end else begin
          e_d   = {e_q[62:0], 1'b0};
          pos_d = pos_q + 6'd1;
        end
      end
      S_PW_SQ, S_PW_MUL: begin
        if (state_q == S_PW_SQ && e_q[63]) begin
          call_en = 1'b1; call_x = z_q; call_y = a_q; call_mont = mont_q;
          call_ret = S_PW_MUL;
        end else if (pos_q == 6'd63) begin
          state_d = S_FIN;
        end else begin
          e_d     = {e_q[62:0], 1'b0};
          pos_d   = pos_q + 6'd1;
          call_en = 1'b1; call_x = z_q; call_y = z_q; call_mont = mont_q;
          call_ret = S_PW_SQ;
        end
      end
      S_INV_MOD: begin
        r0_d    = mod_q;
        r1_d    = z_q;
        t0_d    = '0;
        t1_d    = 64'd1;
        state_d = S_INV_LOOP;
      end
      S_INV_LOOP: begin
        if (r1_q == 64'd0) begin
          if (r0_q != 64'd1) begin
            fail_d  = 1'b1;
            z_d     = '0;
            state_d = S_INV_ADJ;
          end else begin
            call_en  = 1'b1;
            call_x   = t0_q;
            call_y   = mont_q ? r2_q : 64'd1;
            call_ret = S_INV_ADJ;
          end
        end else begin
          dq_d    = r0_q;
          rem_d   = '0;
          cnt_d   = '0;
          state_d = S_INV_DIV;
        end
      end
      S_INV_DIV: begin
        dq_d = {dq_q[62:0], 1'b0};
        if (rem_t >= {1'b0, r1_q}) begin
          rem_d   = 64'(rem_t - {1'b0, r1_q});
          dq_d[0] = 1'b1;
        end else begin
          rem_d = rem_t[63:0];
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd63) begin
          // q * t1 mod p
          call_en  = 1'b1;
          call_x   = dq_d;
          call_y   = t1_q;
          call_ret = S_INV_UPD;
        end
      end
      S_INV_UPD: begin
        r0_d    = r1_q;
        r1_d    = rem_q;
        t0_d    = t1_q;
        t1_d    = nt;
        state_d = S_INV_LOOP;
      end
      S_INV_ADJ: begin
        if (op_q == OP_DIV) begin
          call_en = 1'b1; call_x = a_q; call_y = z_q & WMASK; call_mont = mont_q;
        end else begin
          z_d     = z_q & WMASK;
          state_d = S_FIN;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (call_en) begin
      x_d       = call_mont ? (call_x & km) : call_x;
      y_d       = call_mont ? (call_y & km) : call_y;
      mm_mont_d = call_mont;
      ret_d     = call_ret;
      acc_d     = '0;
      cnt_d     = '0;
      mstep_d   = '0;
      state_d   = S_PROD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_FIN;
      out_valid_q <= 1'b0;
      mod_q       <= 64'hFFFF_FFFF_FFFF_FFC5 & WMASK;
      width_q     <= 7'd64;
      mont_q      <= 1'b0;
      one_q       <= 64'd1;
      r2_q        <= 64'd1;
      ninv_q      <= 64'd1;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_reg_e'(cfg_index_i))
          CFG_MODULUS: mod_q   <= cfg_data_i & WMASK;
          CFG_WIDTH:   width_q <= cfg_data_i[6:0];
          CFG_MONT:    mont_q  <= cfg_data_i[0];
          CFG_ONE:     one_q   <= cfg_data_i & WMASK;
          CFG_R2:      r2_q    <= cfg_data_i & WMASK;
          CFG_NEG_INV: ninv_q  <= cfg_data_i & WMASK;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    a_q       <= a_d;
    x_q       <= x_d;
    y_q       <= y_d;
    z_q       <= z_d;
    r_q       <= r_d;
    e_q       <= e_d;
    r0_q      <= r0_d;
    r1_q      <= r1_d;
    t0_q      <= t0_d;
    t1_q      <= t1_d;
    dq_q      <= dq_d;
    rem_q     <= rem_d;
    acc_q     <= acc_d;
    t_q       <= t_d;
    s_q       <= s_d;
    cnt_q     <= cnt_d;
    pos_q     <= pos_d;
    mstep_q   <= mstep_d;
    mm_mont_q <= mm_mont_d;
    fail_q    <= fail_d;
    res_q     <= res_d;
    zero_q    <= zero_d;
    isone_q   <= isone_d;
    noinv_q   <= noinv_d;
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign cfg_ready_o      = 1'b1;
  assign out_valid_o      = out_valid_q;
  assign result_o         = res_q;
  assign result_is_zero_o = zero_q;
  assign result_is_one_o  = isone_q;
  assign no_inverse_o     = noinv_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_red_nonzero_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RED |-> mod_q != 64'd0)
    else $error("long reduction entered with zero modulus");

  a_fail_only_inverse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && fail_q) |-> (op_q == OP_INV || op_q == OP_DIV))
    else $error("no-inverse flag on an operation without inversion");

  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> result_is_zero_o == (result_o == 64'd0))
    else $error("zero flag disagrees with result");

endmodule

// File: bench/mau_checker.sv
// checker for the modular arithmetic unit: tracks registers, predicts and compares results
`timescale 1ns / 100ps

module mau_checker
  import mau_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [3:0]  operation_i,
  input  logic [63:0] operand_a_i,
  input  logic [63:0] operand_b_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [63:0] result_i,
  input  logic        result_is_zero_i,
  input  logic        result_is_one_i,
  input  logic        no_inverse_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output int          err_count_o,
  output int          pending_o,
  output int          checked_o
);

  typedef struct packed {
    logic [63:0] value;
    logic        is_zero;
    logic        is_one;
    logic        no_inv;
  } mau_result_t;

  mau_result_t result_fifo[$];

  logic [63:0] p_q;
  logic [6:0]  width_q;
  logic        mont_q;
  logic [63:0] one_q;
  logic [63:0] r2_q;
  logic [63:0] ninv_q;

  function automatic int unsigned radix_bits();
    logic [6:0] w;
    w = width_q;
    if (w == 0) w = 1;
    if (w > 64) w = 64;
    return (w > 32) ? 64 : (w > 16) ? 32 : (w > 8) ? 16 : 8;
  endfunction

  function automatic logic [63:0] plain_mulmod(logic [63:0] a, logic [63:0] b);
    logic [127:0] t;
    t = {64'd0, a} * {64'd0, b};
    if (p_q == 0) return t[63:0];
    return 64'(t % {64'd0, p_q});
  endfunction

  function automatic logic [63:0] mont_mulmod(logic [63:0] a, logic [63:0] b);
    int unsigned k;
    logic [63:0]  km, p, n, m;
    logic [129:0] s, u;
    k  = radix_bits();
    km = (k == 64) ? '1 : ((64'd1 << k) - 64'd1);
    p  = p_q & km;
    n  = ninv_q & km;
    a  = a & km;
    b  = b & km;
    s  = {66'd0, a} * {66'd0, b};
    m  = (s[63:0] * n) & km;
    s  = s + {66'd0, m} * {66'd0, p};
    u  = s >> k;
    if (u >= {66'd0, p}) u = u - {66'd0, p};
    return u[63:0] & km;
  endfunction

  function automatic logic [63:0] field_mul(logic [63:0] a, logic [63:0] b);
    return mont_q ? mont_mulmod(a, b) : plain_mulmod(a, b);
  endfunction

  function automatic logic [63:0] add_mod(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, p_q}) s = s - {1'b0, p_q};
    return s[63:0];
  endfunction

  function automatic logic [63:0] sub_mod(logic [63:0] a, logic [63:0] b);
    logic [63:0] d;
    d = a - b;
    if (a < b) d = d + p_q;
    return d;
  endfunction

  function automatic logic [63:0] unit_value();
    return mont_q ? one_q : 64'd1;
  endfunction

  // extended euclid, scaled by r^2 in montgomery form
  function automatic logic [63:0] inverse_mod(logic [63:0] a, output logic fail);
    logic [63:0] r0, r1, t0, t1, q, nr, nt;
    fail = 1'b0;
    if (p_q < 2) begin
      fail = 1'b1;
      return 64'd0;
    end
    r0 = p_q;
    r1 = a % p_q;
    t0 = 0;
    t1 = 1;
    while (r1 != 0) begin
      q  = r0 / r1;
      nr = r0 - q * r1;
      nt = sub_mod(t0, plain_mulmod(q, t1));
      r0 = r1;
      r1 = nr;
      t0 = t1;
      t1 = nt;
    end
    if (r0 != 1) begin
      fail = 1'b1;
      return 64'd0;
    end
    return plain_mulmod(t0, mont_q ? r2_q : 64'd1);
  endfunction

  function automatic logic [63:0] power_mod(logic [63:0] base, logic [63:0] e);
    logic [63:0] r;
    int i;
    r = unit_value();
    i = 63;
    while (i >= 0 && !e[i]) i--;
    for (; i >= 0; i--) begin
      r = field_mul(r, r);
      if (e[i]) r = field_mul(r, base);
    end
    return r;
  endfunction

  function automatic mau_result_t predict_result(logic [3:0] op, logic [63:0] a,
                                                 logic [63:0] b);
    mau_result_t res;
    logic [63:0] r;
    logic fail;
    fail = 1'b0;
    case (op)
      OP_ADD:   r = add_mod(a, b);
      OP_SUB:   r = sub_mod(a, b);
      OP_MUL:   r = field_mul(a, b);
      OP_DIV:   r = field_mul(a, inverse_mod(b, fail));
      OP_NEG:   r = (a == 0) ? 64'd0 : p_q - a;
      OP_DBL:   r = add_mod(a, a);
      OP_SQR:   r = field_mul(a, a);
      OP_POW:   r = power_mod(a, b);
      OP_INV:   r = inverse_mod(a, fail);
      OP_TOM:   r = mont_mulmod(a, r2_q);
      OP_FROMM: r = mont_mulmod(a, 64'd1);
      OP_ONE:   r = unit_value();
      default:  r = 64'd0;
    endcase
    res.value   = r;
    res.is_zero = (r == 0);
    res.is_one  = (r == unit_value());
    res.no_inv  = fail;
    return res;
  endfunction

  initial begin
    err_count_o = 0;
    checked_o   = 0;
    pending_o   = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    mau_result_t want;
    if (!rst_ni) begin
      p_q     <= 64'hFFFF_FFFF_FFFF_FFC5;
      width_q <= 7'd64;
      mont_q  <= 1'b0;
      one_q   <= 64'd1;
      r2_q    <= 64'd1;
      ninv_q  <= 64'd1;
      result_fifo.delete();
      pending_o <= 0;
    end else begin
      // items and register writes never overlap, so the old registers are right here
      if (in_valid_i && !in_stall_i)
        result_fifo.push_back(predict_result(operation_i, operand_a_i, operand_b_i));
      if (out_valid_i && !out_stall_i) begin
        checked_o <= checked_o + 1;
        if (result_fifo.size() == 0) begin
          $display("%0t: result 0x%h with nothing expected", $time, result_i);
          err_count_o <= err_count_o + 1;
        end else begin
          want = result_fifo.pop_front();
          if (want != {result_i, result_is_zero_i, result_is_one_i, no_inverse_i}) begin
            $display("%0t: mismatch expected result=0x%h z=%b o=%b ninv=%b", $time,
                     want.value, want.is_zero, want.is_one, want.no_inv);
            $display("%0t:          actual   result=0x%h z=%b o=%b ninv=%b", $time,
                     result_i, result_is_zero_i, result_is_one_i, no_inverse_i);
            err_count_o <= err_count_o + 1;
          end
        end
      end
      pending_o <= result_fifo.size();
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MODULUS: p_q     <= cfg_data_i;
          CFG_WIDTH:   width_q <= cfg_data_i[6:0];
          CFG_MONT:    mont_q  <= cfg_data_i[0];
          CFG_ONE:     one_q   <= cfg_data_i;
          CFG_R2:      r2_q    <= cfg_data_i;
          CFG_NEG_INV: ninv_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

// File: bench/tb_top.sv
// testbench top: drives the modular arithmetic unit through several field settings
`timescale 1ns / 100ps

module tb_top;
  import mau_pkg::*;

  localparam int unsigned LIMIT = 100_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [3:0]  operation_i;
  logic [63:0] operand_a_i;
  logic [63:0] operand_b_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] result_o;
  logic        result_is_zero_o;
  logic        result_is_one_o;
  logic        no_inverse_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [63:0] cfg_data_i;

  int          err_count;
  int          pending;
  int          checked;
  int unsigned cycles = 0;
  int          settings = 1;
  logic        calm = 1'b0;
  logic [63:0] cur_p = 64'hFFFF_FFFF_FFFF_FFC5;

  modular_arithmetic_unit DUT (.*);

  mau_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i,
    .in_stall_i (in_stall_o),
    .operation_i, .operand_a_i, .operand_b_i,
    .out_valid_i(out_valid_o),
    .out_stall_i, .result_i(result_o),
    .result_is_zero_i(result_is_zero_o),
    .result_is_one_i(result_is_one_o),
    .no_inverse_i(no_inverse_o),
    .cfg_valid_i,
    .cfg_ready_i(cfg_ready_o),
    .cfg_index_i, .cfg_data_i,
    .err_count_o(err_count),
    .pending_o(pending),
    .checked_o(checked)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // result side stalls in bursts, with calm stretches
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      if (!calm && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 30) == 0) begin
        repeat ($urandom_range(20, 200)) @(posedge clk_i);
      end
      @(posedge clk_i);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_item(logic [3:0] op, logic [63:0] a, logic [63:0] b);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // writes a whole field setting, derived constants included
  task automatic set_field(logic [63:0] p, logic [6:0] w, logic mont);
    int unsigned k;
    logic [127:0] one_r, rr;
    logic [63:0] x;
    k = (w > 32) ? 64 : (w > 16) ? 32 : (w > 8) ? 16 : 8;
    one_r = (p == 0) ? 0 : (128'd1 << k) % {64'd0, p};
    rr    = (p == 0) ? 0 : (one_r * one_r) % {64'd0, p};
    x = p;
    repeat (6) x = x * (64'd2 - p * x);
    drain();
    write_reg(CFG_MODULUS, p);
    write_reg(CFG_WIDTH, 64'(w));
    write_reg(CFG_MONT, 64'(mont));
    write_reg(CFG_ONE, one_r[63:0]);
    write_reg(CFG_R2, rr[63:0]);
    write_reg(CFG_NEG_INV, -x);
    cur_p = p;
    settings++;
  endtask

  function automatic logic [63:0] pick_operand();
    logic [63:0] v;
    v = rand64();
    case ($urandom_range(0, 9))
      0:       return 64'd0;
      1:       return 64'd1;
      2:       return cur_p - 1;
      3, 4:    return v;
      default: return (cur_p == 0) ? v : v % cur_p;
    endcase
  endfunction

  function automatic logic [63:0] pick_exponent();
    logic [63:0] e;
    int unsigned nbits;
    e = rand64();
    nbits = ($urandom_range(0, 19) == 0) ? 64 : $urandom_range(0, 10);
    return (nbits == 64) ? e : e & ((64'd1 << nbits) - 1);
  endfunction

  task automatic random_items(int n);
    int unsigned r;
    logic [3:0] op;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40)      op = 4'($urandom_range(OP_NEG, OP_DBL) * (r % 2)) | 4'(r % 2 == 0 ?
                            $urandom_range(OP_ADD, OP_SUB) : 0);
      else if (r < 45) op = OP_ONE;
      else if (r < 70) op = 4'($urandom_range(OP_TOM, OP_FROMM));
      else if (r < 80) op = (r % 2) ? OP_MUL : OP_SQR;
      else if (r < 88) op = OP_POW;
      else if (r < 95) op = (r % 2) ? OP_INV : OP_DIV;
      else             op = 4'($urandom_range(OP_ONE + 1, 15));
      send_item(op, pick_operand(), (op == OP_POW) ? pick_exponent() : pick_operand());
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    operation_i <= OP_ADD;
    operand_a_i <= '0;
    operand_b_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_MODULUS;
    cfg_data_i  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes and corner cases in the reset setting
    send_item(OP_ADD, cur_p - 1, cur_p - 1);
    send_item(OP_ADD, '1, '1);
    send_item(OP_SUB, 64'd0, cur_p - 1);
    send_item(OP_SUB, 64'd0, '1);
    send_item(OP_MUL, cur_p - 1, cur_p - 1);
    send_item(OP_MUL, '1, '1);
    send_item(OP_DIV, 64'd5, 64'd0);
    send_item(OP_DIV, 64'd7, 64'd3);
    send_item(OP_NEG, 64'd0, 64'd0);
    send_item(OP_NEG, '1, 64'd0);
    send_item(OP_DBL, '1, 64'd0);
    send_item(OP_SQR, cur_p - 1, 64'd0);
    send_item(OP_POW, 64'd3, 64'd0);
    send_item(OP_POW, 64'd3, '1);
    send_item(OP_POW, cur_p - 1, 64'h8000_0000_0000_0000);
    send_item(OP_INV, 64'd0, 64'd0);
    send_item(OP_INV, cur_p, 64'd0);
    send_item(OP_INV, 64'd2, 64'd0);
    send_item(OP_TOM, 64'd12345, 64'd0);
    send_item(OP_FROMM, '1, 64'd0);
    send_item(OP_ONE, 64'd0, 64'd0);
    for (int c = 1; c <= 4; c++) send_item(4'(OP_ONE + c), '1, '1);
    random_items(50);

    // unused register indexes must be ignored
    drain();
    write_reg(3'(CFG_NEG_INV + 1), '1);
    write_reg(3'(CFG_NEG_INV + 2), '1);

    set_field(64'd97, 7'd7, 1'b0);                     random_items(60);
    set_field(64'hFFFF_FFFF_FFFF_FFC5, 7'd64, 1'b1);   random_items(70);
    set_field(64'd4294967291, 7'd32, 1'b1);            random_items(60);
    set_field(64'd65521, 7'd16, 1'b1);                 random_items(60);
    set_field(64'd251, 7'd8, 1'b1);                    random_items(60);
    set_field(64'd3, 7'd0, 1'b1);                      random_items(50);
    set_field(64'hFFFF_FFFF_FFFF_FFC5, 7'd127, 1'b1);  random_items(60);
    set_field(64'd2, 7'd1, 1'b0);                      random_items(40);
    set_field(64'd0, 7'd64, 1'b0);                     random_items(40);
    set_field(64'd1, 7'd64, 1'b0);                     random_items(30);
    set_field('1, 7'd64, 1'b0);                        random_items(50);

    // arbitrary constants, plain and montgomery
    drain();
    for (int c = CFG_MODULUS; c <= CFG_NEG_INV; c++) write_reg(3'(c), rand64());
    cur_p = u_checker.p_q;
    settings++;
    random_items(40);
    drain();
    write_reg(CFG_MONT, 64'd1);
    write_reg(CFG_WIDTH, 64'($urandom_range(0, 127)));
    settings++;
    calm = 1'b1;
    random_items(60);

    drain();
    repeat (50) @(posedge clk_i);
    $display("checked %0d results across %0d register settings, plain and montgomery form",
             checked, settings);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/mau_pkg.sv
rtl/core/mau_mul.sv
rtl/core/modular_arithmetic_unit.sv
bench/mau_checker.sv
bench/tb_top.sv
